>>> sv/bdrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdrs_pkg
// Shared sizes, state encoding and controller/datapath interface types for
// the block decomposed range sum unit.
// ----------------------------------------------------------------------------
package bdrs_pkg;

	localparam int NUM_ELEMENTS = 1024;
	localparam int BLOCK_SIZE   = 32;
	localparam int NUM_BLOCKS   = (NUM_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;

	localparam int IDX_W   = 10;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
	localparam int POS_W   = ADDR_W + 1;
	localparam int BLK_SH  = $clog2(BLOCK_SIZE);
	localparam int BADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_UPD_WR,
		ST_Q_RUN,
		ST_Q_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture an input transfer
		logic clr_step;  // write zero at the sweep position, advance
		logic upd_wr;    // write element and adjusted block sum
		logic q_issue;   // read next piece of the range, advance
		logic out_load;  // move the sum into the output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_upd;    // captured item is a point update
		logic skip;      // item needs no memory walk
		logic done;      // walk position is past the range end
		logic clr_last;  // sweep is at the last element
	} dp_stat_t;

endpackage

>>> sv/bdrs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdrs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/bdrs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdrs_datapath
// Element and block-sum memories, walk position, accumulator and output
// data register. Driven by the controller through a command struct.
// ----------------------------------------------------------------------------
module bdrs_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bdrs_pkg::dp_cmd_t           cmd,
	output bdrs_pkg::dp_stat_t          stat,
	input  logic                        mode,
	input  logic [bdrs_pkg::IDX_W-1:0]  left_index,
	input  logic [bdrs_pkg::IDX_W-1:0]  right_index,
	input  logic signed [bdrs_pkg::DATA_W-1:0] new_value,
	output logic signed [bdrs_pkg::DATA_W-1:0] range_sum,
	output logic                        bad_range
);

	localparam int POS_W   = bdrs_pkg::POS_W;
	localparam int ADDR_W  = bdrs_pkg::ADDR_W;
	localparam int BADDR_W = bdrs_pkg::BADDR_W;
	localparam int DATA_W  = bdrs_pkg::DATA_W;

	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  hi_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] acc_q;
	logic              is_upd_q;
	logic              bad_q;
	logic              oob_q;
	logic              pend_s1;
	logic              src_blk_s1;

	logic [DATA_W-1:0]  e_rdata;
	logic [DATA_W-1:0]  b_rdata;
	logic [DATA_W-1:0]  e_wdata;
	logic [DATA_W-1:0]  b_wdata;
	logic [BADDR_W-1:0] b_addr;
	logic [BADDR_W-1:0] b_waddr;
	logic               e_we;
	logic               b_we;
	logic               fit;
	logic               lo_oob;
	logic               hi_oob;
	logic [POS_W:0]     blk_end;

	// range limits of the incoming item
	assign lo_oob = 32'(left_index) >= bdrs_pkg::NUM_ELEMENTS;
	assign hi_oob = 32'(right_index) >= bdrs_pkg::NUM_ELEMENTS;

	// a whole block can be taken when aligned and it ends inside the range
	assign blk_end = (POS_W + 1)'(pos_q) + (POS_W + 1)'(bdrs_pkg::BLOCK_SIZE - 1);
	assign fit = (pos_q[bdrs_pkg::BLK_SH-1:0] == '0) && (blk_end <= (POS_W + 1)'(hi_q));

	assign b_addr = BADDR_W'(pos_q >> bdrs_pkg::BLK_SH);

	// memory write controls: clear sweep or point update
	always_comb begin
		e_we    = cmd.clr_step || cmd.upd_wr;
		b_we    = cmd.upd_wr || (cmd.clr_step && (32'(pos_q) < bdrs_pkg::NUM_BLOCKS));
		e_wdata = cmd.clr_step ? '0 : val_q;
		b_wdata = cmd.clr_step ? '0 : (b_rdata + val_q - e_rdata);
		b_waddr = cmd.clr_step ? BADDR_W'(pos_q) : b_addr;
	end

	bdrs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(bdrs_pkg::NUM_ELEMENTS)
	) u_elem_ram (
		.clk  (clk),
		.we   (e_we),
		.waddr(pos_q[ADDR_W-1:0]),
		.wdata(e_wdata),
		.raddr(pos_q[ADDR_W-1:0]),
		.rdata(e_rdata)
	);

	bdrs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(bdrs_pkg::NUM_BLOCKS)
	) u_blk_ram (
		.clk  (clk),
		.we   (b_we),
		.waddr(b_waddr),
		.wdata(b_wdata),
		.raddr(b_addr),
		.rdata(b_rdata)
	);

	// walk position, also the clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			pend_s1    <= 1'b0;
			src_blk_s1 <= 1'b0;
		end else begin
			pend_s1    <= cmd.q_issue;
			src_blk_s1 <= fit;
			if (cmd.load) begin
				pos_q <= POS_W'(left_index);
			end else if (cmd.clr_step) begin
				pos_q <= pos_q + POS_W'(1);
			end else if (cmd.q_issue) begin
				pos_q <= pos_q + (fit ? POS_W'(bdrs_pkg::BLOCK_SIZE) : POS_W'(1));
			end
		end
	end

	// captured item fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q    <= new_value;
			is_upd_q <= mode;
			oob_q    <= lo_oob;
			bad_q    <= !mode && (left_index > right_index);
			hi_q     <= hi_oob ? POS_W'(bdrs_pkg::NUM_ELEMENTS - 1) : POS_W'(right_index);
		end
	end

	// accumulator: one element or block sum per cycle, added in the cycle after its issue
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else if (pend_s1) begin
			acc_q <= acc_q + (src_blk_s1 ? b_rdata : e_rdata);
		end
	end

	// output data register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			range_sum <= acc_q;
			bad_range <= bad_q;
		end
	end

	always_comb begin
		stat.is_upd   = is_upd_q;
		stat.skip     = is_upd_q ? oob_q : (bad_q || oob_q);
		stat.done     = pos_q > hi_q;
		stat.clr_last = pos_q == POS_W'(bdrs_pkg::NUM_ELEMENTS - 1);
	end

endmodule

>>> sv/bdrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdrs_ctrl
// Sequencer for clear sweep, point updates and range walks; owns the input
// stall and the output valid flag.
// ----------------------------------------------------------------------------
module bdrs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  bdrs_pkg::dp_stat_t stat,
	output bdrs_pkg::dp_cmd_t  cmd
);

	bdrs_pkg::state_t state_q;
	bdrs_pkg::state_t state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdrs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			bdrs_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = bdrs_pkg::ST_IDLE;
				end
			end
			bdrs_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = bdrs_pkg::ST_DECODE;
				end
			end
			bdrs_pkg::ST_DECODE: begin
				if (stat.is_upd) begin
					state_d = stat.skip ? bdrs_pkg::ST_IDLE : bdrs_pkg::ST_UPD_WR;
				end else begin
					state_d = stat.skip ? bdrs_pkg::ST_Q_DONE : bdrs_pkg::ST_Q_RUN;
				end
			end
			bdrs_pkg::ST_UPD_WR: begin
				cmd.upd_wr = 1'b1;
				state_d    = bdrs_pkg::ST_IDLE;
			end
			bdrs_pkg::ST_Q_RUN: begin
				// last pending read lands in the accumulator on the done cycle
				if (stat.done) begin
					state_d = bdrs_pkg::ST_Q_DONE;
				end else begin
					cmd.q_issue = 1'b1;
				end
			end
			bdrs_pkg::ST_Q_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = bdrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bdrs_pkg::ST_CLEAR;
			end
		endcase
	end

	// output valid: set on load, dropped after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall  = state_q != bdrs_pkg::ST_IDLE;

endmodule

>>> sv/block_decomposed_range_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_decomposed_range_sum
// Range sum over 1024 signed 32-bit elements with per-block running sums.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): mode 1 writes new_value at left_index
// and adjusts that block's sum; mode 0 asks for the wrapped sum of
// left_index..right_index. Only queries produce an output transfer
// (range_sum, bad_range on out_valid / out_stall).
// After reset a clearing pass zeroes both memories, one element per cycle,
// with in_stall high.
// An update passes from the transfer through decode with the memory reads
// and the write of element and block sum back to idle for the next accept.
// A query walks the range one memory read per cycle, taking whole block sums
// where a block fits inside the range and single elements at the ends, at
// most 92 reads for a 32-element block; the result is then loaded into the
// output register from Q_DONE and the next item is accepted back in idle.
// Reversed queries and queries whose left_index is out of range skip the walk
// and go from decode straight to Q_DONE.
// Results sit in an output register; the next item is accepted while one
// waits, and a query finishing behind a stalled result holds until the
// result register frees up.
// ----------------------------------------------------------------------------
module block_decomposed_range_sum (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               mode,
	input  logic [bdrs_pkg::IDX_W-1:0]         left_index,
	input  logic [bdrs_pkg::IDX_W-1:0]         right_index,
	input  logic signed [bdrs_pkg::DATA_W-1:0] new_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [bdrs_pkg::DATA_W-1:0] range_sum,
	output logic                               bad_range
);

	bdrs_pkg::dp_cmd_t  cmd;
	bdrs_pkg::dp_stat_t stat;

	bdrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	bdrs_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (mode),
		.left_index (left_index),
		.right_index(right_index),
		.new_value  (new_value),
		.range_sum  (range_sum),
		.bad_range  (bad_range)
	);

	// a reversed range always reports a zero sum
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_range |-> range_sum == '0)
		else $error("bad_range with nonzero sum");

	// one item in flight: a transfer is followed by stall
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on consecutive cycles");

	// a result is never loaded over one that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && out_stall))
		else $error("output register overwritten");

	// no two datapath commands are raised in the same cycle
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.load, cmd.clr_step, cmd.upd_wr, cmd.q_issue, cmd.out_load}) <= 1)
		else $error("conflicting datapath commands");

endmodule

>>> bench/block_decomposed_range_sum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_decomposed_range_sum_tb
// Self-checking bench for the block decomposed range sum unit.
// ----------------------------------------------------------------------------
// A queue of updates and queries (a directed opening, then random traffic)
// feeds a burst/gap driver. A shadow copy of the element store and the block
// sums predicts every query result. A monitor checks each output transfer
// against the oldest prediction. The receiver stalls in changing patterns and
// holds off for long stretches so that the unit backs up into its input.
// ----------------------------------------------------------------------------
module block_decomposed_range_sum_tb;

	import bdrs_pkg::*;

	localparam logic MODE_QUERY  = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	localparam int RANDOM_ITEMS = 1630;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic              mode;
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		logic [DATA_W-1:0] val;
	} range_item_t;

	typedef struct {
		logic [DATA_W-1:0] sum;
		logic              bad;
	} sum_result_t;

	// DUT ports
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     mode = MODE_QUERY;
	logic [IDX_W-1:0]         left_index = '0;
	logic [IDX_W-1:0]         right_index = '0;
	logic signed [DATA_W-1:0] new_value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] range_sum;
	logic                     bad_range;

	// bench state
	range_item_t       pending_items[$];
	sum_result_t       expected_sums[$];
	logic [DATA_W-1:0] shadow_elems[NUM_ELEMENTS];
	logic [DATA_W-1:0] shadow_blocks[NUM_BLOCKS];
	logic              in_fire = 1'b0;
	int                mismatches = 0;

	block_decomposed_range_sum dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.left_index  (left_index),
		.right_index (right_index),
		.new_value   (new_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.range_sum   (range_sum),
		.bad_range   (bad_range)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// shadow model
	// ------------------------------------------------------------------
	function automatic logic [DATA_W-1:0] element_span_sum(int from, int to_incl);
		logic [DATA_W-1:0] acc;
		acc = '0;
		for (int i = from; i <= to_incl; i++)
			acc += shadow_elems[i];
		return acc;
	endfunction

	// wrapped sum: partial ends plus whole block sums in between
	function automatic logic [DATA_W-1:0] wrapped_range_sum(int lo, int hi);
		int                blk_lo;
		int                blk_hi;
		logic [DATA_W-1:0] acc;
		blk_lo = lo >> BLK_SH;
		blk_hi = hi >> BLK_SH;
		if (blk_lo == blk_hi)
			return element_span_sum(lo, hi);
		acc = element_span_sum(lo, (blk_lo + 1) * BLOCK_SIZE - 1);
		for (int b = blk_lo + 1; b < blk_hi; b++)
			acc += shadow_blocks[b];
		acc += element_span_sum(blk_hi * BLOCK_SIZE, hi);
		return acc;
	endfunction

	task automatic track_transfer(logic m, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
			logic [DATA_W-1:0] val);
		sum_result_t res;
		int          top;
		if (m == MODE_UPDATE) begin
			if (int'(lo) < NUM_ELEMENTS) begin
				shadow_blocks[lo >> BLK_SH] += val - shadow_elems[lo];
				shadow_elems[lo] = val;
			end
		end else begin
			res.sum = '0;
			res.bad = 1'b0;
			if (lo > hi) begin
				res.bad = 1'b1;
			end else if (int'(lo) < NUM_ELEMENTS) begin
				top = (int'(hi) >= NUM_ELEMENTS) ? NUM_ELEMENTS - 1 : int'(hi);
				res.sum = wrapped_range_sum(int'(lo), top);
			end
			expected_sums.push_back(res);
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic range_item_t mk_item(logic m, int lo, int hi, logic [DATA_W-1:0] val);
		range_item_t it;
		it.mode = m;
		it.lo   = IDX_W'(lo);
		it.hi   = IDX_W'(hi);
		it.val  = val;
		return it;
	endfunction

	function automatic logic [DATA_W-1:0] random_value();
		case ($urandom_range(0, 19))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			4:       return DATA_W'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	function automatic range_item_t random_item(int upd_pct);
		range_item_t it;
		int          lo;
		int          hi;
		int          b0;
		int          b1;
		it.val = random_value();
		it.hi  = IDX_W'($urandom);
		if ($urandom_range(0, 99) < upd_pct) begin
			it.mode = MODE_UPDATE;
			it.lo   = IDX_W'($urandom);
			return it;
		end
		it.mode = MODE_QUERY;
		case ($urandom_range(0, 9))
			// inside one block
			0, 1: begin
				lo = $urandom_range(0, NUM_ELEMENTS - 1);
				hi = lo + $urandom_range(0, BLOCK_SIZE - 1 - (lo % BLOCK_SIZE));
			end
			// short span that can cross a boundary
			2, 3: begin
				lo = $urandom_range(0, NUM_ELEMENTS - 2 * BLOCK_SIZE);
				hi = lo + $urandom_range(1, 2 * BLOCK_SIZE);
			end
			// arbitrary ordered range
			4, 5: begin
				lo = $urandom_range(0, NUM_ELEMENTS - 1);
				hi = $urandom_range(lo, NUM_ELEMENTS - 1);
			end
			// ends on or one element inside block boundaries
			6: begin
				b0 = $urandom_range(0, NUM_BLOCKS - 1);
				b1 = $urandom_range(b0, NUM_BLOCKS - 1);
				lo = b0 * BLOCK_SIZE + ($urandom_range(0, 1) ? 0 : 1);
				hi = b1 * BLOCK_SIZE + BLOCK_SIZE - 1 - $urandom_range(0, 1);
				if (hi < lo)
					hi = lo;
			end
			// reversed
			7: begin
				lo = $urandom_range(1, NUM_ELEMENTS - 1);
				hi = $urandom_range(0, lo - 1);
			end
			// single element
			8: begin
				lo = $urandom_range(0, NUM_ELEMENTS - 1);
				hi = lo;
			end
			default: begin
				lo = $urandom_range(0, 3);
				hi = NUM_ELEMENTS - 1 - $urandom_range(0, 3);
			end
		endcase
		it.lo = IDX_W'(lo);
		it.hi = IDX_W'(hi);
		return it;
	endfunction

	// ------------------------------------------------------------------
	// prediction on input transfer, check on output transfer
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sum_result_t want;
		in_fire <= in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_sums.size() == 0) begin
				$error("unexpected result: range_sum=%0d bad_range=%0b", range_sum, bad_range);
				mismatches++;
			end else begin
				want = expected_sums.pop_front();
				if (range_sum !== want.sum) begin
					$error("range_sum: expected %0d, got %0d", $signed(want.sum), range_sum);
					mismatches++;
				end
				if (bad_range !== want.bad) begin
					$error("bad_range: expected %0b, got %0b", want.bad, bad_range);
					mismatches++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall)
			track_transfer(mode, left_index, right_index, new_value);
	end

	// ------------------------------------------------------------------
	// driver: bursts of transfers separated by random gaps
	// ------------------------------------------------------------------
	int          burst_left = 4;
	int          gap_left   = 0;
	range_item_t next_item;

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				next_item = pending_items.pop_front();
				mode        <= next_item.mode;
				left_index  <= next_item.lo;
				right_index <= next_item.hi;
				new_value   <= next_item.val;
				in_valid    <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: rotating stall patterns plus long hold-offs
	// ------------------------------------------------------------------
	int rx_cycle = 0;
	int rx_hold  = 0;

	always @(negedge clk) begin
		logic stall_next;
		stall_next = 1'b0;
		if (arst_n) begin
			rx_cycle++;
			if (rx_hold > 0) begin
				rx_hold--;
				stall_next = 1'b1;
			end else if (rx_cycle == 5000 || rx_cycle == 60000) begin
				rx_hold    = 800;
				stall_next = 1'b1;
			end else begin
				case ((rx_cycle / 1500) % 4)
					0:       stall_next = 1'b0;
					1:       stall_next = ($urandom_range(0, 99) < 30);
					2:       stall_next = ($urandom_range(0, 99) < 75);
					default: stall_next = rx_cycle[3];
				endcase
			end
		end
		out_stall <= stall_next;
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		int drain;
		foreach (shadow_elems[i])
			shadow_elems[i] = '0;
		foreach (shadow_blocks[i])
			shadow_blocks[i] = '0;

		// directed opening
		pending_items.push_back(mk_item(MODE_QUERY, 0, NUM_ELEMENTS - 1, 32'h1234_5678));
		pending_items.push_back(mk_item(MODE_UPDATE, 0, 1023, 32'h7FFF_FFFF));
		pending_items.push_back(mk_item(MODE_UPDATE, NUM_ELEMENTS - 1, 0, 32'h8000_0000));
		pending_items.push_back(mk_item(MODE_UPDATE, BLOCK_SIZE - 1, 5, 32'hFFFF_FFFF));
		pending_items.push_back(mk_item(MODE_UPDATE, BLOCK_SIZE, 7, 32'h0000_0001));
		pending_items.push_back(mk_item(MODE_QUERY, 0, NUM_ELEMENTS - 1, 32'hFFFF_FFFF));
		pending_items.push_back(mk_item(MODE_QUERY, NUM_ELEMENTS - 1, NUM_ELEMENTS - 1, 0));
		pending_items.push_back(mk_item(MODE_QUERY, 0, 0, 0));
		pending_items.push_back(mk_item(MODE_QUERY, BLOCK_SIZE - 1, BLOCK_SIZE, 0));
		// reversed ranges
		pending_items.push_back(mk_item(MODE_QUERY, NUM_ELEMENTS - 1, 0, 0));
		pending_items.push_back(mk_item(MODE_QUERY, 1, 0, 0));
		// overwrite adjusts the block sum by the difference
		pending_items.push_back(mk_item(MODE_UPDATE, 0, 0, 32'h0000_0005));
		pending_items.push_back(mk_item(MODE_QUERY, 0, BLOCK_SIZE - 1, 0));
		pending_items.push_back(mk_item(MODE_QUERY, BLOCK_SIZE, NUM_ELEMENTS - 1, 0));
		pending_items.push_back(mk_item(MODE_QUERY, 0, 2 * BLOCK_SIZE - 1, 0));
		// wrap through a positive overflow
		pending_items.push_back(mk_item(MODE_UPDATE, 512, 0, 32'h7FFF_FFFF));
		pending_items.push_back(mk_item(MODE_UPDATE, 513, 0, 32'h7FFF_FFFF));
		pending_items.push_back(mk_item(MODE_QUERY, 512, 513, 0));
		pending_items.push_back(mk_item(MODE_QUERY, 1, NUM_ELEMENTS - 2, 0));
		pending_items.push_back(mk_item(MODE_QUERY, 0, NUM_ELEMENTS - 1, 0));

		// random traffic: load heavily first, then mixed
		for (int n = 0; n < RANDOM_ITEMS; n++)
			pending_items.push_back(random_item((n < 300) ? 80 : 45));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() > 0 || in_valid)
			@(posedge clk);
		drain = 0;
		while (expected_sums.size() > 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		if (expected_sums.size() > 0) begin
			$error("%0d expected results never arrived", expected_sums.size());
			mismatches++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASS block_decomposed_range_sum");
		else
			$display("FAIL block_decomposed_range_sum");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("FAIL block_decomposed_range_sum");
		$finish;
	end

endmodule
